[rtl/core/uws_pkg.sv]
// shared types, constants and helpers for the utf-8 whitespace run segmenter
`default_nettype none

package uws_pkg;

   // byte offsets saturate at 2^POSITION_BITS - 1 (legal range 8..32)
   localparam int POSITION_BITS = 16;
   localparam int OUT_BITS      = 16;

   typedef logic [POSITION_BITS-1:0] pos_type;

   localparam pos_type POS_MAX = {POSITION_BITS{1'b1}};

   // decoupling queue between decoder and run merger
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef logic [1:0] class_type;

   localparam class_type CLASS_WORD    = 2'd0;
   localparam class_type CLASS_SPACE   = 2'd1;
   localparam class_type CLASS_TAB     = 2'd2;
   localparam class_type CLASS_NEWLINE = 2'd3;

   // length of the multi-byte sequence being decoded
   typedef logic [1:0] seq_type;

   localparam seq_type SEQ_NONE  = 2'd0;
   localparam seq_type SEQ_TWO   = 2'd1;
   localparam seq_type SEQ_THREE = 2'd2;
   localparam seq_type SEQ_FOUR  = 2'd3;

   typedef logic [20:0] cp_type;

   localparam cp_type CP_NUL     = 21'h00000;
   localparam cp_type CP_TAB     = 21'h00009;
   localparam cp_type CP_NEWLINE = 21'h0000A;
   localparam cp_type CP_SPACE   = 21'h00020;
   localparam cp_type CP_NBSP    = 21'h000A0;
   localparam cp_type CP_MIN_TWO   = 21'h00080;
   localparam cp_type CP_MIN_THREE = 21'h00800;
   localparam cp_type CP_MIN_FOUR  = 21'h10000;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] seg_offset;
      logic [OUT_BITS-1:0] seg_length;
      class_type           seg_class;
      logic                truncated;
      logic                last_of_item;
   } rsp_type;

   // one decoded event handed from the decoder to the run merger
   typedef struct packed {
      logic      complete;
      logic      nul;
      class_type seg_class;
      pos_type   cp_start;
      pos_type   after;
      logic      end_of_text;
      logic      truncated;
   } event_type;

   function automatic class_type class_of(input cp_type cp);
      class_type cls;
      if (cp == CP_NEWLINE) begin
         cls = CLASS_NEWLINE;
      end else if (cp == CP_TAB) begin
         cls = CLASS_TAB;
      end else if (cp == CP_SPACE || cp == CP_NBSP) begin
         cls = CLASS_SPACE;
      end else begin
         cls = CLASS_WORD;
      end
      return cls;
   endfunction

   // low output bits of a position
   function automatic logic [OUT_BITS-1:0] to_out(input pos_type p);
      logic [31:0] wide;
      wide = 32'(p);
      return wide[OUT_BITS-1:0];
   endfunction

   function automatic rsp_type make_seg(input pos_type   seg_begin,
                                        input pos_type   seg_end,
                                        input class_type cls,
                                        input logic      trunc);
      rsp_type r;
      pos_type len;
      len            = pos_type'(seg_end - seg_begin);
      r.seg_offset   = to_out(seg_begin);
      r.seg_length   = to_out(len);
      r.seg_class    = cls;
      r.truncated    = trunc;
      r.last_of_item = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/uws_front.sv]
// utf-8 decoder and position tracker: turns bytes into codepoint events
`default_nettype none

module uws_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_accept,
   input  uws_pkg::req_type     req_data,
   output logic                 ev_push,
   output uws_pkg::event_type   ev_data
);

   uws_pkg::pos_type pos_ff, pos_in;
   logic             trunc_ff, trunc_in;
   logic             stopped_ff, stopped_in;
   logic [1:0]       pend_ff, pend_in;
   uws_pkg::seq_type seq_ff, seq_in;
   uws_pkg::cp_type  acc_ff, acc_in;
   uws_pkg::pos_type cps_ff, cps_in;

   logic             complete;
   logic             malformed;
   uws_pkg::cp_type  cp;
   uws_pkg::pos_type cp_start;
   logic [7:0]       b;
   logic             eot;

   assign b   = req_data.text_byte;
   assign eot = req_data.end_of_text;

   always_comb begin
      pos_in     = pos_ff;
      trunc_in   = trunc_ff;
      stopped_in = stopped_ff;
      pend_in    = pend_ff;
      seq_in     = seq_ff;
      acc_in     = acc_ff;
      cps_in     = cps_ff;
      complete   = 1'b0;
      malformed  = 1'b0;
      cp         = uws_pkg::CP_NUL;
      cp_start   = cps_ff;

      // saturating position
      if (pos_ff == uws_pkg::POS_MAX) begin
         trunc_in = 1'b1;
      end else begin
         pos_in = uws_pkg::pos_type'(pos_ff + uws_pkg::pos_type'(1));
      end

      if (pend_ff != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            acc_in  = {acc_ff[14:0], b[5:0]};
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               complete = 1'b1;
               cp       = acc_in;
               if ((seq_ff == uws_pkg::SEQ_TWO   && acc_in < uws_pkg::CP_MIN_TWO) ||
                   (seq_ff == uws_pkg::SEQ_THREE && acc_in < uws_pkg::CP_MIN_THREE) ||
                   (seq_ff == uws_pkg::SEQ_FOUR  && acc_in < uws_pkg::CP_MIN_FOUR)) begin
                  malformed = 1'b1;
               end
            end
         end else begin
            // broken sequence absorbs this byte
            complete  = 1'b1;
            malformed = 1'b1;
         end
      end else begin
         cp_start = pos_ff;
         cps_in   = pos_ff;
         if (b < 8'h80) begin
            complete = 1'b1;
            cp       = uws_pkg::cp_type'(b);
         end else if (b < 8'hC0 || b >= 8'hF8) begin
            complete  = 1'b1;
            malformed = 1'b1;
         end else if (b < 8'hE0) begin
            acc_in  = uws_pkg::cp_type'(b[4:0]);
            pend_in = 2'd1;
            seq_in  = uws_pkg::SEQ_TWO;
         end else if (b < 8'hF0) begin
            acc_in  = uws_pkg::cp_type'(b[3:0]);
            pend_in = 2'd2;
            seq_in  = uws_pkg::SEQ_THREE;
         end else begin
            acc_in  = uws_pkg::cp_type'(b[2:0]);
            pend_in = 2'd3;
            seq_in  = uws_pkg::SEQ_FOUR;
         end
      end

      // unfinished sequence at end of text
      if (!complete && eot) begin
         complete  = 1'b1;
         malformed = 1'b1;
      end

      if (complete) begin
         pend_in = 2'd0;
         if (!malformed && cp == uws_pkg::CP_NUL) begin
            stopped_in = 1'b1;
         end
      end

      ev_data.complete    = complete;
      ev_data.nul         = complete && !malformed && (cp == uws_pkg::CP_NUL);
      ev_data.seg_class   = malformed ? uws_pkg::CLASS_WORD : uws_pkg::class_of(cp);
      ev_data.cp_start    = cp_start;
      ev_data.after       = pos_in;
      ev_data.end_of_text = eot;
      ev_data.truncated   = trunc_in;

      // stopped: bytes only advance the position
      if (stopped_ff) begin
         stopped_in = stopped_ff;
         pend_in    = pend_ff;
         seq_in     = seq_ff;
         acc_in     = acc_ff;
         cps_in     = cps_ff;
      end

      // end of text restarts everything for the next text
      if (eot) begin
         pos_in     = '0;
         trunc_in   = 1'b0;
         stopped_in = 1'b0;
         pend_in    = 2'd0;
         seq_in     = uws_pkg::SEQ_NONE;
         acc_in     = '0;
         cps_in     = '0;
      end
   end

   assign ev_push = req_accept && !stopped_ff && (complete || eot);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         trunc_ff   <= 1'b0;
         stopped_ff <= 1'b0;
         pend_ff    <= 2'd0;
         seq_ff     <= uws_pkg::SEQ_NONE;
         acc_ff     <= '0;
         cps_ff     <= '0;
      end else if (req_accept) begin
         pos_ff     <= pos_in;
         trunc_ff   <= trunc_in;
         stopped_ff <= stopped_in;
         pend_ff    <= pend_in;
         seq_ff     <= seq_in;
         acc_ff     <= acc_in;
         cps_ff     <= cps_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/uws_queue.sv]
// small event queue between decoder and run merger
`default_nettype none

module uws_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  uws_pkg::event_type   push_data,
   output logic                 not_full,
   input  wire                  pop,
   output logic                 head_valid,
   output uws_pkg::event_type   head_data
);

   uws_pkg::event_type                 mem_ff [uws_pkg::QUEUE_DEPTH];
   logic [uws_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [uws_pkg::QUEUE_PTR_BITS:0]   count_ff;

   logic do_push;
   logic do_pop;

   assign not_full   = (count_ff != (uws_pkg::QUEUE_PTR_BITS+1)'(uws_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && not_full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == (uws_pkg::QUEUE_PTR_BITS)'(uws_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + (uws_pkg::QUEUE_PTR_BITS)'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == (uws_pkg::QUEUE_PTR_BITS)'(uws_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + (uws_pkg::QUEUE_PTR_BITS)'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (uws_pkg::QUEUE_PTR_BITS+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (uws_pkg::QUEUE_PTR_BITS+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/uws_back.sv]
// run merger: joins codepoints into segments and drives the result register
`default_nettype none

module uws_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  ev_valid,
   input  uws_pkg::event_type   ev,
   output logic                 ev_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output uws_pkg::rsp_type     rsp_data
);

   logic                 run_open_ff, run_open_in;
   uws_pkg::class_type   run_class_ff, run_class_in;
   uws_pkg::pos_type     run_start_ff, run_start_in;

   logic                 rsp_valid_ff;
   uws_pkg::rsp_type     rsp_data_ff;
   logic                 hold_valid_ff;
   uws_pkg::rsp_type     hold_data_ff;

   logic                 open_mid;
   uws_pkg::class_type   class_mid;
   uws_pkg::pos_type     start_mid;
   logic                 close_old, nl_seg, flush;
   logic [1:0]           count;
   uws_pkg::rsp_type     seg_a, seg_b, seg_c, res0, res1;
   logic                 out_free;

   always_comb begin
      open_mid  = run_open_ff;
      class_mid = run_class_ff;
      start_mid = run_start_ff;
      close_old = 1'b0;
      nl_seg    = 1'b0;
      if (ev.complete) begin
         if (ev.nul || ev.seg_class == uws_pkg::CLASS_NEWLINE) begin
            close_old = run_open_ff;
            nl_seg    = !ev.nul;
            open_mid  = 1'b0;
         end else if (!(run_open_ff && run_class_ff == ev.seg_class)) begin
            close_old = run_open_ff;
            open_mid  = 1'b1;
            class_mid = ev.seg_class;
            start_mid = ev.cp_start;
         end
      end
      flush = ev.end_of_text && open_mid;
      count = 2'(close_old) + 2'(nl_seg) + 2'(flush);

      if (ev.end_of_text) begin
         run_open_in  = 1'b0;
         run_class_in = uws_pkg::CLASS_WORD;
         run_start_in = '0;
      end else begin
         run_open_in  = open_mid;
         run_class_in = class_mid;
         run_start_in = start_mid;
      end

      seg_a = uws_pkg::make_seg(run_start_ff, ev.cp_start, run_class_ff, ev.truncated);
      seg_b = uws_pkg::make_seg(ev.cp_start, ev.after, uws_pkg::CLASS_NEWLINE, ev.truncated);
      seg_c = uws_pkg::make_seg(start_mid, ev.after, class_mid, ev.truncated);

      res0 = close_old ? seg_a : (nl_seg ? seg_b : seg_c);
      res1 = (close_old && nl_seg) ? seg_b : seg_c;
      res0.last_of_item = (count == 2'd1);
      res1.last_of_item = 1'b1;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ev_pop   = ev_valid && !hold_valid_ff && (out_free || count == 2'd0);

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         run_class_ff <= run_class_in;
         run_start_ff <= run_start_in;
      end
      if (hold_valid_ff && out_free) begin
         rsp_data_ff <= hold_data_ff;
      end else if (ev_pop && count != 2'd0) begin
         rsp_data_ff  <= res0;
         hold_data_ff <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (ev_pop) begin
            run_open_ff <= run_open_in;
         end
         if (hold_valid_ff && out_free) begin
            rsp_valid_ff  <= 1'b1;
            hold_valid_ff <= 1'b0;
         end else if (ev_pop && count != 2'd0) begin
            rsp_valid_ff  <= 1'b1;
            hold_valid_ff <= (count == 2'd2);
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_hold_behind_out: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("second result held with no first result showing");

   a_pair_fills_hold: assert property (@(posedge clock) disable iff (reset)
      (ev_pop && count == 2'd2) |=> hold_valid_ff)
      else $error("two-result transaction did not park its second result");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> !rsp_data_ff.last_of_item)
      else $error("first of a result pair marked last");

   a_no_pop_while_held: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> !ev_pop)
      else $error("event consumed while a result still waits");

endmodule

`default_nettype wire

[rtl/core/utf8_whitespace_run_segmenter.sv]
// top level of the utf-8 whitespace run segmenter
`default_nettype none

// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_data  (text_byte, end_of_text)
// rsp      out        rsp_valid / rsp_ready  rsp_data  (seg_offset, seg_length,
//                                                       seg_class, truncated, last_of_item)
//
// one byte accepted per cycle while the event queue has room; a byte's
// results leave one per cycle while rsp_ready is high, so a byte that causes
// two segments holds up the run merger until its second result has moved into the result register
// a byte's first result passes through a queue entry and then the result register
// synchronous active-high reset clears positions, decoder, run and queue state
// a stalled rsp side backs up the queue; req_ready drops only when it is full

module utf8_whitespace_run_segmenter (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  uws_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output uws_pkg::rsp_type   rsp_data
);

   logic                 req_accept;
   logic                 ev_push;
   uws_pkg::event_type   ev_in;
   logic                 q_not_full;
   logic                 q_valid;
   uws_pkg::event_type   q_head;
   logic                 q_pop;

   // a transaction is taken whenever the queue can absorb its event
   assign req_ready  = q_not_full;
   assign req_accept = req_valid && req_ready;

   // front: utf-8 decode, classify, track byte offsets and the nul stop
   uws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .ev_push    (ev_push),
      .ev_data    (ev_in)
   );

   // decoupling between decode and run merge
   uws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (ev_push),
      .push_data  (ev_in),
      .not_full   (q_not_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // back: merge runs of one class and present segments
   uws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_valid  (q_valid),
      .ev        (q_head),
      .ev_pop    (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for the utf-8 whitespace run segmenter
`timescale 1ns / 100ps

module testbench;

   // stimulus sizing and run limits
   localparam int          RANDOM_BYTES = 1400;   // random part, on top of the directed rows
   localparam int          IDLE_LIMIT   = 2000;   // cycles with no transaction at all
   localparam int          DRAIN_CYCLES = 20;     // extra wait for stray segments once none are owed
   localparam logic [31:0] POS_LIMIT    = 32'(uws_pkg::POS_MAX);
   localparam int          DIRECTED_ROWS = 26;

   // kinds of codepoint-level tokens the random text generator strings together
   typedef enum int {
      TOK_ASCII, TOK_SPACE, TOK_NBSP, TOK_TAB, TOK_NEWLINE, TOK_TWO, TOK_THREE,
      TOK_FOUR, TOK_NUL, TOK_NOISE, TOK_BROKEN, TOK_OVERLONG
   } token_kind_type;

   // one directed byte; typed rows carry their expected segment by hand
   typedef struct packed {
      logic [7:0]       text_byte;
      logic             eot;
      logic             typed;
      logic [1:0]       count;
      uws_pkg::rsp_type seg;
   } directed_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   uws_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   uws_pkg::rsp_type rsp_data;

   utf8_whitespace_run_segmenter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // segmenter state as the predictor tracks it
   // ---------------------------------------------------------------------
   logic [31:0]        next_offset;     // offset of the next byte, saturating
   logic               run_active;
   uws_pkg::class_type run_cls;
   logic [31:0]        run_begin;
   logic [1:0]         cont_left;       // continuation bytes still owed
   logic [20:0]        cp_accum;
   logic [31:0]        cp_begin;
   logic               halted;          // a nul was seen, waiting for end of text
   int                 seq_bytes;
   logic               past_limit;      // sticky truncation for the current text

   uws_pkg::rsp_type step_segs[$];          // segments caused by the byte being predicted
   uws_pkg::rsp_type expected_segments[$];  // segments still owed by the dut

   // typed expectation for the directed row currently on the bus
   logic             typed_row   = 1'b0;
   int               typed_count = 0;
   uws_pkg::rsp_type typed_seg   = '0;

   // run bookkeeping
   logic steady     = 1'b0;  // when set neither side idles
   logic stim_done  = 1'b0;
   int   failures   = 0;
   int   bytes_sent = 0;     // every accepted byte
   int   live_bytes = 0;     // bytes that reached the decoder (not swallowed after nul)
   int   texts_done = 0;
   int   segs_checked = 0;
   int   trunc_segs = 0;
   int   idle_cycles = 0;
   int   stall_left = 0;

   logic [7:0] text_buf[$];

   task automatic clear_decoder();
      next_offset = '0;
      run_active  = 1'b0;
      run_cls     = uws_pkg::CLASS_WORD;
      run_begin   = '0;
      cont_left   = '0;
      cp_accum    = '0;
      cp_begin    = '0;
      halted      = 1'b0;
      seq_bytes   = 0;
      past_limit  = 1'b0;
   endtask

   function automatic void add_segment(input logic [31:0] seg_from, input logic [31:0] seg_to,
                                       input uws_pkg::class_type cls);
      uws_pkg::rsp_type s;
      logic [31:0]      len;
      len            = seg_to - seg_from;
      s.seg_offset   = seg_from[15:0];
      s.seg_length   = len[15:0];
      s.seg_class    = cls;
      s.truncated    = past_limit;
      s.last_of_item = 1'b0;
      step_segs.push_back(s);
   endfunction

   // decodes one byte, updates the run state and leaves its segments in step_segs
   task automatic predict_byte(input logic [7:0] b, input logic eot);
      logic [31:0]        off;
      logic [31:0]        after_pos;
      logic               done;
      logic               bad;
      logic [20:0]        cp;
      uws_pkg::class_type cls;
      uws_pkg::rsp_type   tail;
      off  = next_offset;
      done = 1'b0;
      bad  = 1'b0;
      cp   = '0;
      step_segs.delete();

      // offsets stop at the limit and every later byte marks the text truncated
      if (next_offset >= POS_LIMIT) begin
         next_offset = POS_LIMIT;
         past_limit  = 1'b1;
      end else begin
         next_offset = next_offset + 1;
      end
      after_pos = next_offset;

      if (halted) begin
         if (eot) clear_decoder();
         return;
      end

      if (cont_left != 0) begin
         if (b[7:6] == 2'b10) begin
            cp_accum  = {cp_accum[14:0], b[5:0]};
            cont_left = cont_left - 1;
            if (cont_left == 0) begin
               done = 1'b1;
               cp   = cp_accum;
               // overlong forms never count as nul or whitespace
               if ((seq_bytes == 2 && cp < uws_pkg::CP_MIN_TWO) ||
                   (seq_bytes == 3 && cp < uws_pkg::CP_MIN_THREE) ||
                   (seq_bytes == 4 && cp < uws_pkg::CP_MIN_FOUR)) begin
                  bad = 1'b1;
               end
            end
         end else begin
            // broken sequence swallows the intruding byte
            done = 1'b1;
            bad  = 1'b1;
         end
      end else begin
         cp_begin = off;
         if (b < 8'h80) begin
            done = 1'b1;
            cp   = {13'b0, b};
         end else if (b < 8'hC0 || b >= 8'hF8) begin
            done = 1'b1;
            bad  = 1'b1;
         end else if (b < 8'hE0) begin
            cp_accum  = {16'b0, b[4:0]};
            cont_left = 2'd1;
            seq_bytes = 2;
         end else if (b < 8'hF0) begin
            cp_accum  = {17'b0, b[3:0]};
            cont_left = 2'd2;
            seq_bytes = 3;
         end else begin
            cp_accum  = {18'b0, b[2:0]};
            cont_left = 2'd3;
            seq_bytes = 4;
         end
      end

      // a sequence cut off by the end of the text is one word codepoint
      if (!done && eot) begin
         done = 1'b1;
         bad  = 1'b1;
      end

      if (done) begin
         cont_left = '0;
         if (!bad && cp == uws_pkg::CP_NUL) begin
            if (run_active) add_segment(run_begin, cp_begin, run_cls);
            run_active = 1'b0;
            halted     = 1'b1;
         end else begin
            if (bad) begin
               cls = uws_pkg::CLASS_WORD;
            end else begin
               case (cp)
                  uws_pkg::CP_NEWLINE:                  cls = uws_pkg::CLASS_NEWLINE;
                  uws_pkg::CP_TAB:                      cls = uws_pkg::CLASS_TAB;
                  uws_pkg::CP_SPACE, uws_pkg::CP_NBSP:  cls = uws_pkg::CLASS_SPACE;
                  default:                              cls = uws_pkg::CLASS_WORD;
               endcase
            end
            if (cls == uws_pkg::CLASS_NEWLINE) begin
               // a newline closes the run and stands alone
               if (run_active) add_segment(run_begin, cp_begin, run_cls);
               add_segment(cp_begin, after_pos, uws_pkg::CLASS_NEWLINE);
               run_active = 1'b0;
            end else if (!(run_active && run_cls == cls)) begin
               if (run_active) add_segment(run_begin, cp_begin, run_cls);
               run_active = 1'b1;
               run_cls    = cls;
               run_begin  = cp_begin;
            end
         end
      end

      if (eot) begin
         if (run_active) add_segment(run_begin, after_pos, run_cls);
         clear_decoder();
      end

      if (step_segs.size() > 0) begin
         tail              = step_segs.pop_back();
         tail.last_of_item = 1'b1;
         step_segs.push_back(tail);
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic compare_field(input string field, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   // drive one transaction at the falling edge and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic eot);
      int               gap;
      uws_pkg::req_type item;
      gap              = pick_gap();
      item.text_byte   = b;
      item.end_of_text = eot;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // appends the bytes of one token of the given kind to text_buf
   task automatic append_token(input token_kind_type kind);
      int          v;
      int          len;
      logic [20:0] cp;
      case (kind)
         TOK_ASCII: begin
            do v = $urandom_range(1, 127); while (v == 9 || v == 10 || v == 32);
            text_buf.push_back(8'(v));
         end
         TOK_SPACE:   text_buf.push_back(8'h20);
         TOK_NBSP: begin
            text_buf.push_back(8'hC2);
            text_buf.push_back(8'hA0);
         end
         TOK_TAB:     text_buf.push_back(8'h09);
         TOK_NEWLINE: text_buf.push_back(8'h0A);
         TOK_NUL:     text_buf.push_back(8'h00);
         TOK_NOISE:   text_buf.push_back(8'($urandom_range(0, 255)));
         TOK_TWO: begin
            cp = 21'($urandom_range(32'h80, 32'h7FF));
            text_buf.push_back({3'b110, cp[10:6]});
            text_buf.push_back({2'b10, cp[5:0]});
         end
         TOK_THREE: begin
            cp = 21'($urandom_range(32'h800, 32'hFFFF));
            text_buf.push_back({4'b1110, cp[15:12]});
            text_buf.push_back({2'b10, cp[11:6]});
            text_buf.push_back({2'b10, cp[5:0]});
         end
         TOK_FOUR: begin
            cp = 21'($urandom_range(32'h10000, 32'h1FFFFF));
            text_buf.push_back({5'b11110, cp[20:18]});
            text_buf.push_back({2'b10, cp[17:12]});
            text_buf.push_back({2'b10, cp[11:6]});
            text_buf.push_back({2'b10, cp[5:0]});
         end
         TOK_BROKEN: begin
            // lead byte, too few continuations, then a byte that is not one
            len = $urandom_range(2, 4);
            if (len == 2)      text_buf.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            else if (len == 3) text_buf.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            else               text_buf.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            repeat ($urandom_range(0, len - 2))
               text_buf.push_back({2'b10, 6'($urandom_range(0, 63))});
            do v = $urandom_range(0, 255); while (v[7:6] == 2'b10);
            text_buf.push_back(8'(v));
         end
         default: begin
            // overlong encodings, often of nul and the whitespace codepoints
            case ($urandom_range(0, 5))
               0:       cp = uws_pkg::CP_NUL;
               1:       cp = uws_pkg::CP_TAB;
               2:       cp = uws_pkg::CP_NEWLINE;
               3:       cp = uws_pkg::CP_SPACE;
               4:       cp = uws_pkg::CP_NBSP;
               default: cp = 21'($urandom_range(0, 127));
            endcase
            len = $urandom_range(2, 4);
            if (len == 2) begin
               text_buf.push_back({3'b110, cp[10:6]});
            end else if (len == 3) begin
               text_buf.push_back({4'b1110, cp[15:12]});
               text_buf.push_back({2'b10, cp[11:6]});
            end else begin
               text_buf.push_back({5'b11110, cp[20:18]});
               text_buf.push_back({2'b10, cp[17:12]});
               text_buf.push_back({2'b10, cp[11:6]});
            end
            text_buf.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // result side back-pressure, changed only at the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || steady) begin
         rsp_ready <= !reset;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predicts on every accepted byte, checks every accepted segment
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      uws_pkg::rsp_type want;
      logic             moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            moved = 1'b1;
            bytes_sent++;
            if (!halted) live_bytes++;
            if (req_data.end_of_text) texts_done++;
            predict_byte(req_data.text_byte, req_data.end_of_text);
            // typed rows replace the predicted segments by hand-written ones
            if (typed_row) begin
               if (typed_count > 0) expected_segments.push_back(typed_seg);
            end else begin
               foreach (step_segs[i]) expected_segments.push_back(step_segs[i]);
            end
         end

         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_segments.size() == 0) begin
               $error("segment with none expected: offset %0d length %0d class %0d",
                      rsp_data.seg_offset, rsp_data.seg_length, rsp_data.seg_class);
               failures++;
            end else begin
               want = expected_segments.pop_front();
               compare_field("seg_offset", want.seg_offset, rsp_data.seg_offset);
               compare_field("seg_length", want.seg_length, rsp_data.seg_length);
               compare_field("seg_class", want.seg_class, rsp_data.seg_class);
               compare_field("truncated", want.truncated, rsp_data.truncated);
               compare_field("last_of_item", want.last_of_item, rsp_data.last_of_item);
               segs_checked++;
               if (rsp_data.truncated) trunc_segs++;
            end
         end

         // watchdog: only counts while work is still outstanding
         if (moved || (stim_done && expected_segments.size() == 0)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d segments outstanding",
                     IDLE_LIMIT, expected_segments.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // directed bytes, one text after another from reset
   // ---------------------------------------------------------------------
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      // plain word closed by end of text
      '{8'h61, 1'b0, 1'b1, 2'd0, '0},
      '{8'h62, 1'b1, 1'b1, 2'd1, '{16'd0, 16'd2, uws_pkg::CLASS_WORD, 1'b0, 1'b1}},
      // nul right away, then end with nothing open
      '{8'h00, 1'b1, 1'b1, 2'd0, '0},
      // invalid top byte as the whole text
      '{8'hFF, 1'b1, 1'b1, 2'd1, '{16'd0, 16'd1, uws_pkg::CLASS_WORD, 1'b0, 1'b1}},
      // space and nbsp merge, tab, newline flushes two segments
      '{8'h20, 1'b0, 1'b0, 2'd0, '0},
      '{8'hC2, 1'b0, 1'b0, 2'd0, '0},
      '{8'hA0, 1'b0, 1'b0, 2'd0, '0},
      '{8'h09, 1'b0, 1'b0, 2'd0, '0},
      '{8'h0A, 1'b0, 1'b0, 2'd0, '0},
      // stray continuation byte
      '{8'h80, 1'b0, 1'b0, 2'd0, '0},
      // overlong three-byte nul
      '{8'hE0, 1'b0, 1'b0, 2'd0, '0},
      '{8'h80, 1'b0, 1'b0, 2'd0, '0},
      '{8'h80, 1'b0, 1'b0, 2'd0, '0},
      // overlong two-byte newline
      '{8'hC0, 1'b0, 1'b0, 2'd0, '0},
      '{8'h8A, 1'b0, 1'b0, 2'd0, '0},
      // four-byte lead broken by an ascii byte
      '{8'hF0, 1'b0, 1'b0, 2'd0, '0},
      '{8'h41, 1'b0, 1'b0, 2'd0, '0},
      // highest unicode scalar, four bytes
      '{8'hF4, 1'b0, 1'b0, 2'd0, '0},
      '{8'h8F, 1'b0, 1'b0, 2'd0, '0},
      '{8'hBF, 1'b0, 1'b0, 2'd0, '0},
      '{8'hBF, 1'b0, 1'b0, 2'd0, '0},
      // nul flushes the word run, later bytes ignored through the end
      '{8'h00, 1'b0, 1'b0, 2'd0, '0},
      '{8'h0A, 1'b0, 1'b0, 2'd0, '0},
      '{8'h7F, 1'b1, 1'b0, 2'd0, '0},
      // lead byte left unfinished at end of text
      '{8'hE2, 1'b1, 1'b1, 2'd1, '{16'd0, 16'd1, uws_pkg::CLASS_WORD, 1'b0, 1'b1}},
      // lone newline as a whole text
      '{8'h0A, 1'b1, 1'b1, 2'd1, '{16'd0, 16'd1, uws_pkg::CLASS_NEWLINE, 1'b0, 1'b1}}
   };

   // ---------------------------------------------------------------------
   // stimulus: reset, directed table, then random texts
   // ---------------------------------------------------------------------
   initial begin
      token_kind_type kind;
      int             r;
      int             n_runs;
      int             sent_start;

      clear_decoder();
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         typed_row   = directed_table[i].typed;
         typed_count = directed_table[i].count;
         typed_seg   = directed_table[i].seg;
         send_byte(directed_table[i].text_byte, directed_table[i].eot);
      end
      typed_row = 1'b0;

      // random texts: runs of same-kind tokens, with noise, broken and
      // overlong sequences and the odd nul mixed in
      sent_start = bytes_sent;
      while (bytes_sent - sent_start < RANDOM_BYTES) begin
         text_buf.delete();
         steady = ($urandom_range(0, 4) == 0);
         n_runs = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         repeat (n_runs) begin
            r = $urandom_range(0, 99);
            if (r < 30)      kind = TOK_ASCII;
            else if (r < 45) kind = TOK_SPACE;
            else if (r < 50) kind = TOK_NBSP;
            else if (r < 57) kind = TOK_TAB;
            else if (r < 64) kind = TOK_NEWLINE;
            else if (r < 72) kind = TOK_TWO;
            else if (r < 78) kind = TOK_THREE;
            else if (r < 83) kind = TOK_FOUR;
            else if (r < 85) kind = TOK_NUL;
            else if (r < 91) kind = TOK_NOISE;
            else if (r < 96) kind = TOK_BROKEN;
            else             kind = TOK_OVERLONG;
            repeat ($urandom_range(1, 4)) append_token(kind);
         end
         // sometimes leave a sequence open on the end byte
         if ($urandom_range(0, 7) == 0) text_buf.push_back(8'($urandom_range(8'hC2, 8'hF7)));
         foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      stim_done = 1'b1;

      // wait out every owed segment, then keep watching for strays
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d texts in %0d bytes, %0d of them decoded, the rest swallowed after a nul",
               texts_done, bytes_sent, live_bytes);
      $display("compared %0d segments, %0d of them flagged truncated",
               segs_checked, trunc_segs);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
